### src/tws_pkg.sv
// ----------------------------------------------------------------------------
// tws_pkg
// shared types and constants of the three-wire serial master
// ----------------------------------------------------------------------------
package tws_pkg;

    localparam logic [4:0] MAX_DATA_BYTES = 5'd31;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic       ce;
        logic       sclk;
        logic       io_out;
        logic       io_drive;
        logic       busy;
        logic       wdata_taken;
        logic [7:0] rdata;
        logic       rdata_valid;
        logic       done;
    } t_result;

endpackage

### src/tws_seq.sv
// ----------------------------------------------------------------------------
// tws_seq
// half-bit phase sequencer: one step per accepted request
// ----------------------------------------------------------------------------
module tws_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [1:0]       i_op,
    input  logic [7:0]       i_command,
    input  logic [4:0]       i_data_bytes,
    input  logic [7:0]       i_wdata,
    input  logic             i_io_in,
    output tws_pkg::t_result o_res
);

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_CMD_LOW   = 3'd1,
        PH_CMD_HIGH  = 3'd2,
        PH_WR_LOW    = 3'd3,
        PH_WR_HIGH   = 3'd4,
        PH_RD_FALL   = 3'd5,
        PH_RD_SAMPLE = 3'd6,
        PH_FINISH    = 3'd7
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [2:0] r_bit_index, n_bit_index;
    logic [4:0] r_bytes_left, n_bytes_left;
    logic [7:0] r_shift_byte, n_shift_byte;
    logic       r_is_read, n_is_read;
    logic       r_clock_level, n_clock_level;
    logic       r_enable_level, n_enable_level;

    logic [4:0] start_count;
    logic [4:0] dec_bytes;
    logic       io_out, io_drive, taken, rvalid, done;
    logic [7:0] rdata;

    always_comb begin
        if (i_data_bytes == 5'd0) begin
            start_count = 5'd1;
        end else if (i_data_bytes > tws_pkg::MAX_DATA_BYTES) begin
            start_count = tws_pkg::MAX_DATA_BYTES;
        end else begin
            start_count = i_data_bytes;
        end
    end

    assign dec_bytes = r_bytes_left - 5'd1;

    always_comb begin
        n_phase        = r_phase;
        n_bit_index    = r_bit_index;
        n_bytes_left   = r_bytes_left;
        n_shift_byte   = r_shift_byte;
        n_is_read      = r_is_read;
        n_clock_level  = r_clock_level;
        n_enable_level = r_enable_level;
        io_out         = 1'b0;
        io_drive       = 1'b0;
        taken          = 1'b0;
        rvalid         = 1'b0;
        rdata          = 8'd0;
        done           = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_op == tws_pkg::OP_WRITE || i_op == tws_pkg::OP_READ) begin
                    n_bytes_left   = start_count;
                    n_is_read      = (i_op == tws_pkg::OP_READ);
                    n_shift_byte   = i_command;
                    n_bit_index    = 3'd0;
                    n_enable_level = 1'b1;
                    n_clock_level  = 1'b0;
                    io_drive       = 1'b1;
                    io_out         = i_command[0];
                    n_phase        = PH_CMD_HIGH;
                end
            end
            PH_CMD_LOW, PH_WR_LOW: begin
                if (r_phase == PH_WR_LOW && r_bit_index == 3'd0) begin
                    n_shift_byte = i_wdata;
                    taken        = 1'b1;
                end
                n_clock_level = 1'b0;
                io_drive      = 1'b1;
                io_out        = n_shift_byte[0];
                n_phase       = (r_phase == PH_CMD_LOW) ? PH_CMD_HIGH : PH_WR_HIGH;
            end
            PH_CMD_HIGH, PH_WR_HIGH: begin
                n_clock_level = 1'b1;
                io_drive      = 1'b1;
                io_out        = r_shift_byte[0];
                n_shift_byte  = {1'b0, r_shift_byte[7:1]};
                if (r_bit_index == 3'd7) begin
                    n_bit_index = 3'd0;
                    if (r_phase == PH_CMD_HIGH) begin
                        n_phase = r_is_read ? PH_RD_FALL : PH_WR_LOW;
                    end else begin
                        n_bytes_left = dec_bytes;
                        n_phase      = (dec_bytes == 5'd0) ? PH_FINISH : PH_WR_LOW;
                    end
                end else begin
                    n_bit_index = r_bit_index + 3'd1;
                    n_phase     = (r_phase == PH_CMD_HIGH) ? PH_CMD_LOW : PH_WR_LOW;
                end
            end
            PH_RD_FALL: begin
                n_clock_level = 1'b0;
                n_phase       = PH_RD_SAMPLE;
            end
            PH_RD_SAMPLE: begin
                n_shift_byte  = {i_io_in, r_shift_byte[7:1]};
                n_clock_level = 1'b1;
                n_phase       = PH_RD_FALL;
                if (r_bit_index == 3'd7) begin
                    n_bit_index  = 3'd0;
                    rdata        = n_shift_byte;
                    rvalid       = 1'b1;
                    n_bytes_left = dec_bytes;
                    if (dec_bytes == 5'd0) begin
                        n_clock_level = 1'b0;
                        n_phase       = PH_FINISH;
                    end
                end else begin
                    n_bit_index = r_bit_index + 3'd1;
                end
            end
            PH_FINISH: begin
                n_enable_level = 1'b0;
                n_clock_level  = 1'b0;
                done           = 1'b1;
                n_phase        = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_bit_index    <= 3'd0;
            r_bytes_left   <= 5'd0;
            r_shift_byte   <= 8'd0;
            r_is_read      <= 1'b0;
            r_clock_level  <= 1'b0;
            r_enable_level <= 1'b0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_bit_index    <= n_bit_index;
            r_bytes_left   <= n_bytes_left;
            r_shift_byte   <= n_shift_byte;
            r_is_read      <= n_is_read;
            r_clock_level  <= n_clock_level;
            r_enable_level <= n_enable_level;
        end
    end

    always_comb begin
        o_res.ce          = n_enable_level;
        o_res.sclk        = n_clock_level;
        o_res.io_out      = io_out;
        o_res.io_drive    = io_drive;
        o_res.busy        = (n_phase != PH_IDLE);
        o_res.wdata_taken = taken;
        o_res.rdata       = rdata;
        o_res.rdata_valid = rvalid;
        o_res.done        = done;
    end

`ifndef SYNTH
    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> !r_enable_level && !r_clock_level)
        else $error("idle with chip enable or clock high");
    a_bytes_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_WR_LOW || r_phase == PH_RD_FALL || r_phase == PH_RD_SAMPLE)
        |-> r_bytes_left != 5'd0)
        else $error("data phase with no bytes left");
    a_finish_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_FINISH && i_step |=> r_phase == PH_IDLE)
        else $error("finish step did not return to idle");
`endif

endmodule

### src/three_wire_serial_master.sv
// ----------------------------------------------------------------------------
// three_wire_serial_master
// lsb-first three-wire serial master, one half-bit phase per request
// ----------------------------------------------------------------------------
// input channel: i_in_valid / o_in_ready carry one request per half-bit tick:
// op (tick, start write, start read), command byte, data byte count, the next
// write byte and the sampled level of the data line.
// output channel: o_out_valid / i_out_ready carry one result per request:
// chip enable, clock and data line levels, busy, write byte taken, read byte
// and its valid flag, and transaction done.
// latency: the result of a request is valid the cycle after it is accepted.
// throughput: one request per cycle unless the receiver stalls; the phase
// sequencer steps once per accepted request and the result register is
// refilled in the same cycle it is drained.
// a stalled receiver holds the result register; o_in_ready stays low until
// the result is taken, so no request is lost or repeated.
// reset returns the sequencer to idle with chip enable and clock low and
// empties the result register.
// ----------------------------------------------------------------------------
module three_wire_serial_master (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_op,
    input  logic [7:0] i_command,
    input  logic [4:0] i_data_bytes,
    input  logic [7:0] i_wdata,
    input  logic       i_io_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_ce,
    output logic       o_sclk,
    output logic       o_io_out,
    output logic       o_io_drive,
    output logic       o_busy_res,
    output logic       o_wdata_taken,
    output logic [7:0] o_rdata,
    output logic       o_rdata_valid,
    output logic       o_done_res
);

    tws_pkg::t_result step_res;
    tws_pkg::t_result r_res;
    logic             r_out_valid;
    logic             accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    tws_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (accept),
        .i_op         (i_op),
        .i_command    (i_command),
        .i_data_bytes (i_data_bytes),
        .i_wdata      (i_wdata),
        .i_io_in      (i_io_in),
        .o_res        (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= step_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_ce          = r_res.ce;
    assign o_sclk        = r_res.sclk;
    assign o_io_out      = r_res.io_out;
    assign o_io_drive    = r_res.io_drive;
    assign o_busy_res    = r_res.busy;
    assign o_wdata_taken = r_res.wdata_taken;
    assign o_rdata       = r_res.rdata;
    assign o_rdata_valid = r_res.rdata_valid;
    assign o_done_res    = r_res.done;

`ifndef SYNTH
    a_done_drops_ce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_ce && !o_sclk && !o_busy_res)
        else $error("done reported with chip enable, clock or busy high");
    a_read_write_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_rdata_valid && (o_wdata_taken || o_io_drive)))
        else $error("read byte reported while driving the line");
    a_released_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_io_drive |-> !o_io_out)
        else $error("data bit set while line released");
    a_drive_in_txn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_io_drive |-> o_ce && o_busy_res)
        else $error("line driven outside a transaction");
`endif

endmodule
